/* rtl/rfs_pkg.sv */
// ----------------------------------------------------------------------------
// rfs_pkg
// Shared constants, types and float32 helper functions of the repulsion block.
// ----------------------------------------------------------------------------
package rfs_pkg;

  localparam int MaxObstacles    = 128;
  localparam int IdxW            = $clog2(MaxObstacles);
  localparam int CntW            = $clog2(MaxObstacles + 1);
  localparam int DivStages       = 9;
  localparam int DivBitsPerStage = 3;
  localparam int QuotW           = DivStages * DivBitsPerStage;

  localparam logic [31:0] CanonNan = 32'h7FC0_0000;

  typedef enum logic {
    OpLoad  = 1'b0,
    OpQuery = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    RegInUse = 2'd0,
    RegNumer = 2'd1,
    RegEps   = 2'd2
  } reg_e;

  // what rides along with one obstacle through the divider
  typedef struct packed {
    logic [31:0] dx;
    logic        last;
  } tag_t;

  function automatic logic is_nan(logic [31:0] x);
    return (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
  endfunction

  function automatic logic is_inf(logic [31:0] x);
    return (x[30:23] == 8'hFF) && (x[22:0] == 23'd0);
  endfunction

  function automatic logic is_zero(logic [31:0] x);
    return x[30:0] == 31'd0;
  endfunction

  function automatic logic [23:0] sig_of(logic [31:0] x);
    return {x[30:23] != 8'd0, x[22:0]};
  endfunction

  function automatic logic signed [11:0] exp_of(logic [31:0] x);
    return $signed({4'b0, (x[30:23] == 8'd0) ? 8'd1 : x[30:23]});
  endfunction

  function automatic logic [4:0] lzc24(logic [23:0] x);
    logic [4:0] n;
    logic       found;
    n     = '0;
    found = 1'b0;
    for (int i = 23; i >= 0; i--) begin
      if (!found) begin
        if (x[i]) found = 1'b1;
        else      n = n + 5'd1;
      end
    end
    return n;
  endfunction

  // Normalise, round to nearest even and pack. Value is f / 2^49 * 2^(e-127);
  // st carries any nonzero bits below f.
  function automatic logic [31:0] fp_round(logic s, logic signed [11:0] e,
                                           logic [49:0] f, logic st);
    logic [5:0]         lz;
    logic               found;
    logic [49:0]        fn;
    logic signed [11:0] ee;
    logic [11:0]        shamt;
    logic [5:0]         sh;
    logic [99:0]        wide;
    logic [23:0]        m24;
    logic               g;
    logic               stk;
    logic               up;
    logic [24:0]        m25;
    logic [31:0]        r;
    lz    = '0;
    found = 1'b0;
    for (int i = 49; i >= 0; i--) begin
      if (!found) begin
        if (f[i]) found = 1'b1;
        else      lz = lz + 6'd1;
      end
    end
    fn  = f << lz;
    ee  = e - $signed({6'b0, lz});
    stk = st;
    if (ee < 12'sd1) begin
      // drop into the subnormal range
      shamt = 12'(12'sd1 - ee);
      sh    = (shamt > 12'd63) ? 6'd63 : shamt[5:0];
      wide  = {fn, 50'b0} >> sh;
      fn    = wide[99:50];
      stk   = stk | (|wide[49:0]);
      ee    = 12'sd1;
    end
    m24 = fn[49:26];
    g   = fn[25];
    stk = stk | (|fn[24:0]);
    up  = g & (stk | m24[0]);
    m25 = {1'b0, m24} + {24'b0, up};
    if (m25[24]) begin
      m24 = m25[24:1];
      ee  = ee + 12'sd1;
    end else begin
      m24 = m25[23:0];
    end
    if (f == 50'd0)           r = {s, 31'b0};
    else if (ee >= 12'sd255)  r = {s, 8'hFF, 23'b0};
    else if (!m24[23])        r = {s, 8'h00, m24[22:0]};
    else                      r = {s, ee[7:0], m24[22:0]};
    return r;
  endfunction

  function automatic logic [31:0] fp_mul(logic [31:0] a, logic [31:0] b);
    logic        s;
    logic [47:0] p;
    logic [31:0] r;
    s = a[31] ^ b[31];
    p = sig_of(a) * sig_of(b);
    if (is_nan(a) || is_nan(b))                                r = CanonNan;
    else if ((is_inf(a) && is_zero(b)) || (is_zero(a) && is_inf(b))) r = CanonNan;
    else if (is_inf(a) || is_inf(b))                           r = {s, 8'hFF, 23'b0};
    else if (is_zero(a) || is_zero(b))                         r = {s, 31'b0};
    else r = fp_round(s, exp_of(a) + exp_of(b) - 12'sd126, {p, 2'b0}, 1'b0);
    return r;
  endfunction

  function automatic logic [31:0] fp_add(logic [31:0] a, logic [31:0] b);
    logic [31:0]        hi;
    logic [31:0]        lo;
    logic signed [11:0] eh;
    logic [11:0]        d;
    logic [5:0]         sh;
    logic [99:0]        wide;
    logic [49:0]        av;
    logic [49:0]        bv;
    logic [49:0]        rv;
    logic [31:0]        r;
    if ((exp_of(a) < exp_of(b)) ||
        ((exp_of(a) == exp_of(b)) && (sig_of(a) < sig_of(b)))) begin
      hi = b;
      lo = a;
    end else begin
      hi = a;
      lo = b;
    end
    eh   = exp_of(hi);
    d    = 12'(eh - exp_of(lo));
    sh   = (d > 12'd63) ? 6'd63 : d[5:0];
    av   = {1'b0, sig_of(hi), 25'b0};
    wide = {1'b0, sig_of(lo), 25'b0, 50'b0} >> sh;
    bv   = wide[99:50] | {49'b0, |wide[49:0]};
    rv   = (a[31] ^ b[31]) ? (av - bv) : (av + bv);
    if (is_nan(a) || is_nan(b))                           r = CanonNan;
    else if (is_inf(a) && is_inf(b) && (a[31] != b[31]))  r = CanonNan;
    else if (is_inf(a))                                   r = a;
    else if (is_inf(b))                                   r = b;
    else if (is_zero(a) && is_zero(b))                    r = {a[31] & b[31], 31'b0};
    else if (is_zero(a))                                  r = b;
    else if (is_zero(b))                                  r = a;
    else if (rv == 50'd0)                                 r = 32'd0;
    else r = fp_round(hi[31], eh + 12'sd1, rv, 1'b0);
    return r;
  endfunction

endpackage

/* rtl/repulsive_force_sum.sv */
// ----------------------------------------------------------------------------
// repulsive_force_sum
// Sideways repulsion summed over a table of obstacles, float32 throughout.
// ----------------------------------------------------------------------------
// A load transfer (tuser = 0) writes one obstacle into the 128-entry x/y
// table. A query transfer (tuser = 1) walks obstacles 0 .. n-1, with n the
// in-use register saturated at 128, and returns sum(dx * k / (d2*d2)),
// d2 = dx*dx + dy*dy + epsilon, each operation rounded to nearest even. One
// obstacle enters the float pipeline per cycle; its stages are table read,
// subtract, square, two adds, square, a divider of nine three-bit stages plus
// its entry and rounding registers, multiply and accumulate. The result goes
// to the output register once the last term is summed and the register is
// free, with no terms to sum when nothing is in use. The block takes
// no input while a query is running; a finished result waits in the output
// register, and the next item is taken meanwhile. Entries never loaded read
// as garbage.
// Configuration: write only while idle; index 0 in-use count, 1 gain k bits,
// 2 epsilon bits.
module repulsive_force_sum (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,   // obstacle_slot[6:0], pos_x[38:7], pos_y[70:39], pad
  input  logic        s_axis_tuser,   // operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // force_sum[31:0]
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);
  import rfs_pkg::*;

  logic [7:0]  in_use_q;
  logic [31:0] numer_q;
  logic [31:0] eps_q;

  logic [31:0] mem_x [MaxObstacles];
  logic [31:0] mem_y [MaxObstacles];

  logic            busy_q, issuing_q, done_q;
  logic [CntW-1:0] idx_q, cnt_q, cnt_d;
  logic [31:0]     rx_q, ry_q, acc_q;

  logic        v0_q, l0_q, v1_q, l1_q, v2_q, l2_q, v3_q, l3_q, v4_q, l4_q, v5_q, l5_q;
  logic        vt_q, lt_q;
  logic [31:0] ox_q, oy_q, dx1_q, dy1_q, dx2_q, sx2_q, sy2_q, dx3_q, s3_q;
  logic [31:0] dx4_q, d2_4_q, dx5_q, den5_q, term_q;

  logic        dv;
  logic [31:0] str;
  tag_t        dtag;
  tag_t        tag5;

  logic        in_fire, out_free, query_go;

  assign s_axis_tready = !busy_q;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign query_go      = in_fire && (op_e'(s_axis_tuser) == OpQuery);
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  // saturate the in-use count at the table depth
  assign cnt_d = (in_use_q > 8'(MaxObstacles)) ? CntW'(MaxObstacles) : CntW'(in_use_q);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_use_q <= 8'd128;
      numer_q  <= 32'h447A_0000;
      eps_q    <= 32'h3DCC_CCCD;
    end else if (cfg_we_i) begin
      unique case (reg_e'(cfg_idx_i))
        RegInUse: in_use_q <= cfg_data_i[7:0];
        RegNumer: numer_q  <= cfg_data_i;
        RegEps:   eps_q    <= cfg_data_i;
        default:  ;
      endcase
    end
  end

  // obstacle table: write on load, registered read at the issue index
  always_ff @(posedge clk_i) begin
    if (in_fire && (op_e'(s_axis_tuser) == OpLoad) &&
        (32'(s_axis_tdata[6:0]) < MaxObstacles)) begin
      mem_x[IdxW'(s_axis_tdata[6:0])] <= s_axis_tdata[38:7];
      mem_y[IdxW'(s_axis_tdata[6:0])] <= s_axis_tdata[70:39];
    end
    ox_q <= mem_x[idx_q[IdxW-1:0]];
    oy_q <= mem_y[idx_q[IdxW-1:0]];
  end

  // query control: issue one obstacle a cycle, then hold the sum until the
  // output register is free
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      issuing_q <= 1'b0;
      done_q    <= 1'b0;
      idx_q     <= '0;
      v0_q      <= 1'b0;
    end else begin
      v0_q <= issuing_q;
      if (query_go) begin
        busy_q    <= 1'b1;
        idx_q     <= '0;
        issuing_q <= (cnt_d != '0);
        done_q    <= (cnt_d == '0);
      end else begin
        if (issuing_q) begin
          idx_q <= idx_q + CntW'(1);
          if (idx_q == cnt_q - CntW'(1)) issuing_q <= 1'b0;
        end
        if (vt_q && lt_q) done_q <= 1'b1;
        if (done_q && out_free) begin
          done_q <= 1'b0;
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    l0_q <= (idx_q == cnt_q - CntW'(1));
    if (query_go) begin
      cnt_q <= cnt_d;
      rx_q  <= s_axis_tdata[38:7];
      ry_q  <= s_axis_tdata[70:39];
    end
  end

  // valid bits of the float pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      vt_q <= 1'b0;
    end else begin
      v1_q <= v0_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      vt_q <= dv;
    end
  end

  // float pipeline: subtract, square, sum, add epsilon, square, and the final multiply
  always_ff @(posedge clk_i) begin
    dx1_q  <= fp_add(rx_q, {~ox_q[31], ox_q[30:0]});
    dy1_q  <= fp_add(ry_q, {~oy_q[31], oy_q[30:0]});
    l1_q   <= l0_q;
    sx2_q  <= fp_mul(dx1_q, dx1_q);
    sy2_q  <= fp_mul(dy1_q, dy1_q);
    dx2_q  <= dx1_q;
    l2_q   <= l1_q;
    s3_q   <= fp_add(sx2_q, sy2_q);
    dx3_q  <= dx2_q;
    l3_q   <= l2_q;
    d2_4_q <= fp_add(s3_q, eps_q);
    dx4_q  <= dx3_q;
    l4_q   <= l3_q;
    den5_q <= fp_mul(d2_4_q, d2_4_q);
    dx5_q  <= dx4_q;
    l5_q   <= l4_q;
    term_q <= fp_mul(dtag.dx, str);
    lt_q   <= dtag.last;
  end

  assign tag5.dx   = dx5_q;
  assign tag5.last = l5_q;

  rfs_div_pipe u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (v5_q),
    .num_i       (numer_q),
    .den_i       (den5_q),
    .in_tag_i    (tag5),
    .out_valid_o (dv),
    .quot_o      (str),
    .out_tag_o   (dtag)
  );

  // serial accumulation in obstacle order
  always_ff @(posedge clk_i) begin
    if (query_go) begin
      acc_q <= 32'd0;
    end else if (vt_q) begin
      acc_q <= fp_add(acc_q, term_q);
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tvalid <= 1'b0;
    end else if (done_q && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done_q && out_free) begin
      m_axis_tdata <= is_nan(acc_q) ? CanonNan : acc_q;
    end
  end

endmodule

/* rtl/rfs_div_pipe.sv */
// ----------------------------------------------------------------------------
// rfs_div_pipe
// Pipelined float32 divider, three quotient bits per stage, one op per cycle.
// ----------------------------------------------------------------------------
module rfs_div_pipe (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic [31:0]         num_i,
  input  logic [31:0]         den_i,
  input  rfs_pkg::tag_t       in_tag_i,
  output logic                out_valid_o,
  output logic [31:0]         quot_o,
  output rfs_pkg::tag_t       out_tag_o
);
  import rfs_pkg::*;

  typedef struct packed {
    tag_t               tag;
    logic               spec;
    logic [31:0]        spec_val;
    logic               sign;
    logic signed [11:0] e;
    logic [24:0]        rem;
    logic [QuotW-1:0]   quot;
    logic [23:0]        dvs;
  } div_t;

  logic [DivStages:0] v_q;
  div_t               st_q [DivStages+1];
  div_t               prep_d;
  div_t               step_d [DivStages];
  logic               ov_q;
  logic [31:0]        quot_q;
  tag_t               otag_q;

  // classify specials and normalise both significands
  always_comb begin
    logic [4:0]  lza;
    logic [4:0]  lzb;
    logic        s;
    lza = lzc24(sig_of(num_i));
    lzb = lzc24(sig_of(den_i));
    s   = num_i[31] ^ den_i[31];
    prep_d.tag      = in_tag_i;
    prep_d.sign     = s;
    prep_d.e        = exp_of(num_i) - $signed({7'b0, lza})
                      - exp_of(den_i) + $signed({7'b0, lzb}) + 12'sd127;
    prep_d.rem      = {1'b0, sig_of(num_i) << lza};
    prep_d.dvs      = sig_of(den_i) << lzb;
    prep_d.quot     = '0;
    prep_d.spec     = 1'b1;
    prep_d.spec_val = CanonNan;
    if (is_nan(num_i) || is_nan(den_i)) begin
      prep_d.spec_val = CanonNan;
    end else if (is_zero(den_i)) begin
      prep_d.spec_val = is_zero(num_i) ? CanonNan : {num_i[31], 8'hFF, 23'b0};
    end else if (is_inf(num_i) && is_inf(den_i)) begin
      prep_d.spec_val = CanonNan;
    end else if (is_inf(num_i)) begin
      prep_d.spec_val = {s, 8'hFF, 23'b0};
    end else if (is_inf(den_i) || is_zero(num_i)) begin
      prep_d.spec_val = {s, 31'b0};
    end else begin
      prep_d.spec = 1'b0;
    end
  end

  // restoring steps
  always_comb begin
    for (int i = 0; i < DivStages; i++) begin
      step_d[i] = st_q[i];
      for (int j = 0; j < DivBitsPerStage; j++) begin
        if (step_d[i].rem >= {1'b0, step_d[i].dvs}) begin
          step_d[i].quot = {step_d[i].quot[QuotW-2:0], 1'b1};
          step_d[i].rem  = (step_d[i].rem - {1'b0, step_d[i].dvs}) << 1;
        end else begin
          step_d[i].quot = {step_d[i].quot[QuotW-2:0], 1'b0};
          step_d[i].rem  = step_d[i].rem << 1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q  <= '0;
      ov_q <= 1'b0;
    end else begin
      v_q  <= {v_q[DivStages-1:0], in_valid_i};
      ov_q <= v_q[DivStages];
    end
  end

  always_ff @(posedge clk_i) begin
    st_q[0] <= prep_d;
    for (int i = 0; i < DivStages; i++) begin
      st_q[i+1] <= step_d[i];
    end
    otag_q <= st_q[DivStages].tag;
    quot_q <= st_q[DivStages].spec ? st_q[DivStages].spec_val
            : fp_round(st_q[DivStages].sign, st_q[DivStages].e,
                       {st_q[DivStages].quot, 23'b0}, st_q[DivStages].rem != 25'd0);
  end

  assign out_valid_o = ov_q;
  assign quot_o      = quot_q;
  assign out_tag_o   = otag_q;

endmodule
